@@ design/sit_pkg.sv @@
// shared constants and types for the segment intersection test
`timescale 1ns / 1ps

package sit_pkg;

   // register stages from request to response: differences, products, cross sums, compare
   localparam int PIPE_DEPTH = 4;

   // per-stage valid and ready vectors
   typedef logic [PIPE_DEPTH-1:0] stage_flag_type;

endpackage

@@ design/sit_req_if.sv @@
// request channel: two segments given by their end points
`timescale 1ns / 1ps

interface sit_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_start_x;
   logic signed [COORD_WIDTH-1:0] first_start_y;
   logic signed [COORD_WIDTH-1:0] first_end_x;
   logic signed [COORD_WIDTH-1:0] first_end_y;
   logic signed [COORD_WIDTH-1:0] second_start_x;
   logic signed [COORD_WIDTH-1:0] second_start_y;
   logic signed [COORD_WIDTH-1:0] second_end_x;
   logic signed [COORD_WIDTH-1:0] second_end_y;

   modport source (
      output valid,
      input  ready,
      output first_start_x, first_start_y, first_end_x, first_end_y,
      output second_start_x, second_start_y, second_end_x, second_end_y
   );

   modport sink (
      input  valid,
      output ready,
      input  first_start_x, first_start_y, first_end_x, first_end_y,
      input  second_start_x, second_start_y, second_end_x, second_end_y
   );
endinterface

@@ design/sit_rsp_if.sv @@
// response channel: intersection flag
`timescale 1ns / 1ps

interface sit_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (
      output valid,
      input  ready,
      output hit
   );

   modport sink (
      input  valid,
      output ready,
      input  hit
   );
endinterface

@@ design/segment_intersection_test_2d.sv @@
// pipelined 2d segment intersection test with endpoint contact counted as a hit
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-------------------------------------------
//   req     | in  | valid/ready  | first/second segment start and end x, y
//   rsp     | out | valid/ready  | hit
//
// one request per cycle while the response side keeps taking results; each response passes
// the register stages for differences, products, cross sums and sign compare
// synchronous active-high reset empties all stages; data registers are not reset
// each stage holds while the stage after it is full and not moving
`timescale 1ns / 1ps

module segment_intersection_test_2d #(
   parameter int COORD_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   sit_req_if.sink    req,
   sit_rsp_if.source  rsp
);

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;

   // stage valid bits and the ready chain
   sit_pkg::stage_flag_type vld_ff;
   sit_pkg::stage_flag_type vld_in;
   sit_pkg::stage_flag_type adv;

   always_comb begin
      adv[sit_pkg::PIPE_DEPTH-1] = !vld_ff[sit_pkg::PIPE_DEPTH-1] || rsp.ready;
      for (int k = sit_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = req.valid;
      end
      for (int k = 1; k < sit_pkg::PIPE_DEPTH; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = adv[0];

   // stage 1: edge vectors and the offset between start points
   logic signed [DIFF_W-1:0] ax_in, ay_in, bx_in, by_in, vx_in, vy_in;
   logic signed [DIFF_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, vx_ff, vy_ff;
   logic                     proper_in, proper1_ff;

   always_comb begin
      ax_in = $signed({req.first_end_x[COORD_WIDTH-1], req.first_end_x})
            - $signed({req.first_start_x[COORD_WIDTH-1], req.first_start_x});
      ay_in = $signed({req.first_end_y[COORD_WIDTH-1], req.first_end_y})
            - $signed({req.first_start_y[COORD_WIDTH-1], req.first_start_y});
      bx_in = $signed({req.second_end_x[COORD_WIDTH-1], req.second_end_x})
            - $signed({req.second_start_x[COORD_WIDTH-1], req.second_start_x});
      by_in = $signed({req.second_end_y[COORD_WIDTH-1], req.second_end_y})
            - $signed({req.second_start_y[COORD_WIDTH-1], req.second_start_y});
      vx_in = $signed({req.first_start_x[COORD_WIDTH-1], req.first_start_x})
            - $signed({req.second_start_x[COORD_WIDTH-1], req.second_start_x});
      vy_in = $signed({req.first_start_y[COORD_WIDTH-1], req.first_start_y})
            - $signed({req.second_start_y[COORD_WIDTH-1], req.second_start_y});
      // a segment with coinciding ends never hits
      proper_in = (req.first_start_x != req.first_end_x
                   || req.first_start_y != req.first_end_y)
               && (req.second_start_x != req.second_end_x
                   || req.second_start_y != req.second_end_y);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ax_ff      <= ax_in;
         ay_ff      <= ay_in;
         bx_ff      <= bx_in;
         by_ff      <= by_in;
         vx_ff      <= vx_in;
         vy_ff      <= vy_in;
         proper1_ff <= proper_in;
      end
   end

   // stage 2: the six partial products
   logic signed [PROD_W-1:0] axby_in, aybx_in, vybx_in, vxby_in, vyax_in, vxay_in;
   logic signed [PROD_W-1:0] axby_ff, aybx_ff, vybx_ff, vxby_ff, vyax_ff, vxay_ff;
   logic                     proper2_ff;

   always_comb begin
      axby_in = ax_ff * by_ff;
      aybx_in = ay_ff * bx_ff;
      vybx_in = vy_ff * bx_ff;
      vxby_in = vx_ff * by_ff;
      vyax_in = vy_ff * ax_ff;
      vxay_in = vx_ff * ay_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         axby_ff    <= axby_in;
         aybx_ff    <= aybx_in;
         vybx_ff    <= vybx_in;
         vxby_ff    <= vxby_in;
         vyax_ff    <= vyax_in;
         vxay_ff    <= vxay_in;
         proper2_ff <= proper1_ff;
      end
   end

   // stage 3: denominator and the two numerators
   logic signed [CROSS_W-1:0] den_in, tn_in, sn_in;
   logic signed [CROSS_W-1:0] den_ff, tn_ff, sn_ff;
   logic                      proper3_ff;

   always_comb begin
      den_in = $signed({axby_ff[PROD_W-1], axby_ff}) - $signed({aybx_ff[PROD_W-1], aybx_ff});
      tn_in  = $signed({vybx_ff[PROD_W-1], vybx_ff}) - $signed({vxby_ff[PROD_W-1], vxby_ff});
      sn_in  = $signed({vyax_ff[PROD_W-1], vyax_ff}) - $signed({vxay_ff[PROD_W-1], vxay_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         den_ff     <= den_in;
         tn_ff      <= tn_in;
         sn_ff      <= sn_in;
         proper3_ff <= proper2_ff;
      end
   end

   // stage 4: both ratios in [0, 1] by sign and magnitude against the denominator
   logic den_pos, den_neg, tn_ok, sn_ok;
   logic hit_in, hit_ff;

   always_comb begin
      den_pos = !den_ff[CROSS_W-1] && (den_ff != '0);
      den_neg = den_ff[CROSS_W-1];
      priority if (den_pos) begin
         tn_ok = !tn_ff[CROSS_W-1] && (tn_ff <= den_ff);
         sn_ok = !sn_ff[CROSS_W-1] && (sn_ff <= den_ff);
      end else if (den_neg) begin
         tn_ok = (tn_ff[CROSS_W-1] || (tn_ff == '0)) && (tn_ff >= den_ff);
         sn_ok = (sn_ff[CROSS_W-1] || (sn_ff == '0)) && (sn_ff >= den_ff);
      end else begin
         // parallel or collinear
         tn_ok = 1'b0;
         sn_ok = 1'b0;
      end
      hit_in = proper3_ff && tn_ok && sn_ok;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp.valid = vld_ff[sit_pkg::PIPE_DEPTH-1];
   assign rsp.hit   = hit_ff;

endmodule

@@ design/sit_checker.sv @@
// port-level checks for the segment intersection test, bound to the top level
`timescale 1ns / 1ps

module sit_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   // a pending response stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
   else $error("response dropped while stalled");

   // a stalled response keeps its flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit))
   else $error("response changed while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("response offered right after reset");

   // with the output stage empty every stage can move, so requests are taken
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
   else $error("request blocked with empty output stage");

   // a request waiting on a full output can only be blocked by downstream backpressure
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
   else $error("request blocked without backpressure");

endmodule

bind segment_intersection_test_2d sit_checker u_sit_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_hit   (rsp.hit)
);

@@ test/testbench.sv @@
// self-checking testbench for the pipelined 2d segment intersection test
`timescale 1ns / 1ps

module testbench;

   localparam int COORD_WIDTH = 16;
   localparam int CLOCK_PERIOD = 8;
   localparam int RANDOM_ITEMS = 1950;
   localparam int IDLE_PERCENT = 6;
   localparam int MAX_REPORTS = 10;
   // sender never idles in this window of random requests
   localparam int BURST_FIRST = 700;
   localparam int BURST_LAST = 1099;
   // receiver never stalls in this window of cycles, which covers the sender burst
   localparam int STEADY_FIRST = 500;
   localparam int STEADY_LAST = 1499;
   // sender holds off here until every response is back
   localparam int DRAIN_ITEM = 1300;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // two segments: first from start to end, second from start to end
   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_end_x;
      coord_type second_end_y;
   } segment_pair_type;

   // how a directed row gets its expected hit
   typedef enum logic [1:0] {
      HIT_PREDICTED,
      HIT_NO,
      HIT_YES
   } hit_note_type;

   typedef struct packed {
      segment_pair_type pair;
      hit_note_type     note;
   } directed_row_type;

   typedef struct packed {
      segment_pair_type pair;
      logic             hit;
   } hit_expect_type;

   localparam int DIRECTED_ROWS = 22;

   // directed requests: degenerate, parallel, collinear, endpoint touches, extremes
   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0}, HIT_NO},
      '{'{5, 5, 5, 5, 0, 0, 10, 10}, HIT_NO},
      '{'{0, 0, 10, 10, 5, 5, 5, 5}, HIT_NO},
      '{'{-1, -1, -1, -1, -1, -1, -1, -1}, HIT_NO},
      '{'{0, 0, 10, 10, 0, 10, 10, 0}, HIT_YES},
      '{'{10, 10, 0, 0, 10, 0, 0, 10}, HIT_YES},
      '{'{0, 0, 10, 0, 0, 5, 10, 5}, HIT_NO},
      '{'{0, 0, 10, 0, 5, 0, 15, 0}, HIT_NO},
      '{'{0, 0, 10, 0, 0, 10, 0, 0}, HIT_YES},
      '{'{0, 0, 10, 0, 0, 0, 0, 10}, HIT_YES},
      '{'{0, 0, 10, 0, 10, -5, 10, 5}, HIT_YES},
      '{'{0, 0, 10, 0, 11, -5, 11, 5}, HIT_NO},
      '{'{0, 0, 10, 0, 5, 0, 5, 7}, HIT_YES},
      '{'{0, 0, 1, 1, 10, 0, 0, 10}, HIT_NO},
      '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, HIT_YES},
      '{'{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767}, HIT_NO},
      '{'{-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767}, HIT_YES},
      '{'{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}, HIT_YES},
      '{'{-32768, 32767, -32768, -32768, 32767, 0, -1, 0}, HIT_PREDICTED},
      '{'{21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846}, HIT_PREDICTED},
      '{'{-7, 3, 4, -9, 2, 8, -3, -6}, HIT_PREDICTED},
      '{'{100, -200, -300, 400, -100, -50, 60, 70}, HIT_PREDICTED}
   };

   logic clock = 1'b0;
   logic reset;

   sit_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_if ();
   sit_rsp_if rsp_if ();

   hit_expect_type expected_hits [$];
   int mismatch_count = 0;
   int rsp_cycle = 0;

   segment_intersection_test_2d #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // coordinate widened to 64 bits with its sign
   function automatic longint widen(input coord_type c);
      return longint'(c);
   endfunction

   // true when num / den lies in [0, 1]; den is nonzero
   function automatic bit ratio_in_unit(input longint num, input longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   // exact intersection test on cross products, no division
   function automatic logic predict_hit(input segment_pair_type p);
      longint ax, ay, bx, by, vx, vy, den, t_num, s_num;
      ax = widen(p.first_end_x) - widen(p.first_start_x);
      ay = widen(p.first_end_y) - widen(p.first_start_y);
      bx = widen(p.second_end_x) - widen(p.second_start_x);
      by = widen(p.second_end_y) - widen(p.second_start_y);
      vx = widen(p.first_start_x) - widen(p.second_start_x);
      vy = widen(p.first_start_y) - widen(p.second_start_y);
      // a segment collapsed to a point never hits
      if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return 1'b0;
      den = ax * by - ay * bx;
      // parallel and collinear pairs count as no hit
      if (den == 0) return 1'b0;
      t_num = vy * bx - vx * by;
      s_num = vy * ax - vx * ay;
      return ratio_in_unit(t_num, den) && ratio_in_unit(s_num, den);
   endfunction

   // random segment pair: wide, tiny box, built-in touch, or extreme codes
   function automatic segment_pair_type random_pair();
      segment_pair_type p;
      int kind, k, px, py, qx, qy, tx, ty, ux, uy, pick;
      kind = $urandom_range(99);
      p = '0;
      if (kind < 40) begin
         p = {$urandom, $urandom, $urandom, $urandom};
      end else if (kind < 70) begin
         // small grid gives many touches, collinear and degenerate pairs
         for (k = 0; k < 8; k++)
            p[COORD_WIDTH*k +: COORD_WIDTH] = coord_type'(int'($urandom_range(16)) - 8);
      end else if (kind < 85) begin
         // one end of the second segment lies at an end or the midpoint of the first
         px = 2 * (int'($urandom_range(1000)) - 500);
         py = 2 * (int'($urandom_range(1000)) - 500);
         qx = 2 * (int'($urandom_range(1000)) - 500);
         qy = 2 * (int'($urandom_range(1000)) - 500);
         pick = $urandom_range(2);
         tx = (pick == 0) ? px : (pick == 1) ? qx : (px + qx) / 2;
         ty = (pick == 0) ? py : (pick == 1) ? qy : (py + qy) / 2;
         ux = int'($urandom_range(2000)) - 1000;
         uy = int'($urandom_range(2000)) - 1000;
         if ($urandom_range(1)) begin
            k = tx; tx = ux; ux = k;
            k = ty; ty = uy; uy = k;
         end
         p.first_start_x = coord_type'(px);
         p.first_start_y = coord_type'(py);
         p.first_end_x = coord_type'(qx);
         p.first_end_y = coord_type'(qy);
         p.second_start_x = coord_type'(tx);
         p.second_start_y = coord_type'(ty);
         p.second_end_x = coord_type'(ux);
         p.second_end_y = coord_type'(uy);
      end else begin
         for (k = 0; k < 8; k++) begin
            case ($urandom_range(4))
               0: p[COORD_WIDTH*k +: COORD_WIDTH] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
               1: p[COORD_WIDTH*k +: COORD_WIDTH] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
               2: p[COORD_WIDTH*k +: COORD_WIDTH] = '0;
               3: p[COORD_WIDTH*k +: COORD_WIDTH] = '1;
               default: p[COORD_WIDTH*k +: COORD_WIDTH] = coord_type'($urandom);
            endcase
         end
      end
      return p;
   endfunction

   // drive one request at the falling edge and hold it until accepted
   task automatic send_pair(input segment_pair_type p, input logic hit, input bit may_idle);
      while (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.first_start_x <= p.first_start_x;
      req_if.first_start_y <= p.first_start_y;
      req_if.first_end_x <= p.first_end_x;
      req_if.first_end_y <= p.first_end_y;
      req_if.second_start_x <= p.second_start_x;
      req_if.second_start_y <= p.second_start_y;
      req_if.second_end_x <= p.second_end_x;
      req_if.second_end_y <= p.second_end_y;
      do @(posedge clock); while (!req_if.ready);
      expected_hits.push_back('{pair: p, hit: hit});
      @(negedge clock);
   endtask

   // response ready with random stalls, steady inside one window
   initial rsp_if.ready = 1'b0;
   always @(negedge clock) begin
      rsp_cycle++;
      if (rsp_cycle >= STEADY_FIRST && rsp_cycle <= STEADY_LAST)
         rsp_if.ready <= 1'b1;
      else
         rsp_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
   end

   // compare each accepted response with the oldest expected hit
   always @(posedge clock) begin
      hit_expect_type oldest;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: hit %0b at %0t", rsp_if.hit, $realtime);
         end else begin
            oldest = expected_hits.pop_front();
            if (rsp_if.hit !== oldest.hit) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("hit mismatch for pair %h: expected %0b, actual %0b",
                     oldest.pair, oldest.hit, rsp_if.hit);
            end
         end
      end
   end

   // stimulus: reset, directed table, random requests, drain and verdict
   initial begin
      int row, item;
      segment_pair_type pair;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.first_start_x = '0;
      req_if.first_start_y = '0;
      req_if.first_end_x = '0;
      req_if.first_end_y = '0;
      req_if.second_start_x = '0;
      req_if.second_start_y = '0;
      req_if.second_end_x = '0;
      req_if.second_end_y = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         pair = directed_rows[row].pair;
         case (directed_rows[row].note)
            HIT_YES: send_pair(pair, 1'b1, 1'b1);
            HIT_NO: send_pair(pair, 1'b0, 1'b1);
            default: send_pair(pair, predict_hit(pair), 1'b1);
         endcase
      end

      for (item = 0; item < RANDOM_ITEMS; item++) begin
         if (item == DRAIN_ITEM) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
            while (expected_hits.size() != 0) @(negedge clock);
         end
         pair = random_pair();
         send_pair(pair, predict_hit(pair), !(item >= BURST_FIRST && item <= BURST_LAST));
      end
      req_if.valid <= 1'b0;

      while (expected_hits.size() != 0) @(posedge clock);
      repeat (4 * sit_pkg::PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog against a stuck handshake
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
